// File: rtl/core/ngga_pkg.sv
package ngga_pkg;

	// Capture window prefix and its length in bytes
	localparam logic [47:0] PREFIX_GPGGA = 48'h244750474741;
	localparam int          PREFIX_LEN   = 6;

	// Characters
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Field positions within a GGA sentence
	localparam logic [3:0] FLD_LAT     = 4'd2;
	localparam logic [3:0] FLD_LAT_DIR = 4'd3;
	localparam logic [3:0] FLD_LON     = 4'd4;
	localparam logic [3:0] FLD_LON_DIR = 4'd5;
	localparam logic [3:0] FLD_FIX     = 4'd6;
	localparam logic [3:0] FLD_ALT     = 4'd9;
	localparam logic [3:0] FLD_LAST    = 4'd15;

	// Accumulator ceiling and per-field limits
	localparam logic [29:0] ACC_CAP = 30'd1000000000;
	localparam logic [43:0] LAT_MAX = 44'd99999999;
	localparam logic [43:0] LON_MAX = 44'd999999999;
	localparam logic [43:0] FIX_MAX = 44'd255;
	localparam logic [43:0] ALT_MAX = 44'd99999999;

	typedef struct packed {
		logic [29:0] acc;
		logic [2:0]  frac_digits;
		logic        any;
		logic        started;
		logic        neg;
		logic        frac;
		logic        stop;
	} num_t;

	typedef struct packed {
		logic [26:0]        lat;
		logic [29:0]        lon;
		logic [7:0]         fix;
		logic signed [27:0] alt;
	} fin_t;

	typedef struct packed {
		logic [7:0] rx_byte;
	} char_t;

	typedef struct packed {
		logic [26:0]        latitude;
		logic [7:0]         latitude_hemisphere;
		logic [29:0]        longitude;
		logic [7:0]         longitude_hemisphere;
		logic [7:0]         fix_quality;
		logic signed [27:0] altitude;
	} fix_t;

	// Number of fraction digits kept for a numeric field
	function automatic logic [2:0] field_scale(input logic [3:0] f);
		logic [2:0] s;
		case (f)
			FLD_LAT, FLD_LON: s = 3'd4;
			FLD_ALT:          s = 3'd2;
			default:          s = 3'd0;
		endcase
		return s;
	endfunction

	function automatic logic field_numeric(input logic [3:0] f);
		return (f == FLD_LAT) || (f == FLD_LON) || (f == FLD_FIX) || (f == FLD_ALT);
	endfunction

endpackage

// File: rtl/core/ngga_stream_if.sv
interface ngga_stream_if #(
	parameter type payload_t = logic [7:0]
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// File: rtl/core/ngga_take.sv
// Fold one character into the running number of the current field.
module ngga_take (
	input  logic [7:0]    ch,
	input  logic [3:0]    field,
	input  ngga_pkg::num_t cur,
	output ngga_pkg::num_t nxt,
	output logic          first
);
	import ngga_pkg::*;

	logic [2:0]  scale;
	logic        is_digit;
	logic        is_ws;
	logic [33:0] acc10;
	logic [29:0] acc_sat;

	assign scale    = field_scale(field);
	assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign is_ws    = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_LF) ||
	                  (ch == CH_CR) || (ch == CH_VT) || (ch == CH_FF);
	assign acc10    = {1'b0, cur.acc, 3'b000} + {3'b000, cur.acc, 1'b0} + {30'd0, ch[3:0]};
	// clamp: any value beyond the cap saturates every field's result anyway
	assign acc_sat  = (acc10 > {4'd0, ACC_CAP}) ? ACC_CAP : acc10[29:0];
	assign first    = !cur.any;

	always_comb begin
		nxt     = cur;
		nxt.any = 1'b1;
		if (field_numeric(field) && !cur.stop) begin
			if (is_digit) begin
				nxt.started = 1'b1;
				if (!cur.frac) begin
					nxt.acc = acc_sat;
				end else if (cur.frac_digits < scale) begin
					nxt.acc         = acc_sat;
					nxt.frac_digits = cur.frac_digits + 3'd1;
				end
			end else if (!cur.started && is_ws) begin
				// skip leading white space
			end else if (!cur.started && (ch == CH_PLUS || ch == CH_MINUS)) begin
				nxt.started = 1'b1;
				nxt.neg     = (ch == CH_MINUS);
			end else if (ch == CH_DOT && !cur.frac) begin
				nxt.started = 1'b1;
				nxt.frac    = 1'b1;
			end else begin
				nxt.stop = 1'b1;
			end
		end
	end
endmodule

// File: rtl/core/ngga_finish.sv
// Scale the accumulated number to its fixed-point unit and saturate.
module ngga_finish (
	input  logic [3:0]     field,
	input  ngga_pkg::num_t cur,
	output ngga_pkg::fin_t vals
);
	import ngga_pkg::*;

	logic [2:0]  shift;
	logic [13:0] pow;
	logic [43:0] v;
	logic [26:0] alt_mag;
	logic [27:0] alt_ext;

	assign shift = field_scale(field) - cur.frac_digits;

	always_comb begin
		case (shift)
			3'd0:    pow = 14'd1;
			3'd1:    pow = 14'd10;
			3'd2:    pow = 14'd100;
			3'd3:    pow = 14'd1000;
			default: pow = 14'd10000;
		endcase
	end

	assign v = {14'd0, cur.acc} * {30'd0, pow};

	assign alt_mag = (v > ALT_MAX) ? ALT_MAX[26:0] : v[26:0];
	assign alt_ext = {1'b0, alt_mag};

	always_comb begin
		vals.lat = cur.neg ? 27'd0 : ((v > LAT_MAX) ? LAT_MAX[26:0] : v[26:0]);
		vals.lon = cur.neg ? 30'd0 : ((v > LON_MAX) ? LON_MAX[29:0] : v[29:0]);
		vals.fix = cur.neg ? 8'd0  : ((v > FIX_MAX) ? FIX_MAX[7:0]  : v[7:0]);
		vals.alt = cur.neg ? -$signed(alt_ext) : $signed(alt_ext);
	end
endmodule

// File: rtl/core/nmea_gga_sentence_parser_unit.sv
// GGA sentence parser. Received characters enter on the chars channel, one
// request per byte, and each completed "$GPGGA" sentence leaves as one request
// on the fixes channel when its line feed arrives: latitude and longitude in
// units of 1e-4 of ddmm.mmmm / dddmm.mmmm, the two hemisphere characters
// (space when empty), the fix quality and the altitude in centimeters. Fields
// are located by comma position, so empty fields read as zero; text after the
// checksum star is ignored, and a sentence longer than MAX_CAPTURE-1 bytes is
// dropped without a result. Each byte is held in an input register and folded
// into the parser state from there, where a completed sentence also loads the
// output register: a byte is taken every cycle while the fixes side keeps up,
// and the result is offered once its line feed is folded in. A stalled result
// holds back new bytes only when the input register is full as well.
module nmea_gga_sentence_parser_unit #(
	parameter int MAX_CAPTURE = 128
) (
	input logic           clk,
	input logic           arst_n,
	ngga_stream_if.sink   chars,
	ngga_stream_if.source fixes
);
	import ngga_pkg::*;

	localparam int LEN_W = $clog2(MAX_CAPTURE);
	localparam logic [LEN_W-1:0] LEN_LAST  = LEN_W'(MAX_CAPTURE - 1);
	localparam logic [LEN_W-1:0] LEN_START = LEN_W'(PREFIX_LEN);
	localparam logic [LEN_W-1:0] LEN_ONE   = LEN_W'(1);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// parser state
	logic [47:0]        win_q;
	logic               capturing_q;
	logic [LEN_W-1:0]   len_q;
	logic [3:0]         field_q;
	logic               star_q;
	num_t               num_q;
	logic [26:0]        lat_q;
	logic [29:0]        lon_q;
	logic [7:0]         lat_dir_q;
	logic [7:0]         lon_dir_q;
	logic [7:0]         fix_q;
	logic signed [27:0] alt_q;

	// result register
	logic res_valid_q;
	fix_t res_q;

	logic        advance;
	logic        step;
	logic [47:0] win_next;
	logic        over;
	logic        is_lf;
	logic        is_comma;
	logic        is_end;
	logic        emit;
	num_t        num_take;
	logic        dir_first;
	fin_t        fin_vals;
	fix_t        res_d;

	ngga_take u_take (
		.ch    (byte_s1),
		.field (field_q),
		.cur   (num_q),
		.nxt   (num_take),
		.first (dir_first)
	);

	ngga_finish u_finish (
		.field (field_q),
		.cur   (num_q),
		.vals  (fin_vals)
	);

	// advance the input stage whenever the result register is free or draining
	assign advance     = !res_valid_q || fixes.ready;
	assign chars.ready = !valid_s1 || advance;
	assign step        = valid_s1 && advance;

	assign win_next = {win_q[39:0], byte_s1};
	assign over     = len_q >= LEN_LAST;
	assign is_lf    = byte_s1 == CH_LF;
	assign is_comma = byte_s1 == CH_COMMA;
	assign is_end   = (byte_s1 == CH_STAR) || (byte_s1 == CH_NUL);
	assign emit     = capturing_q && !over && is_lf;

	// result as seen after the closing field is folded in
	always_comb begin
		res_d.latitude  = (!star_q && field_q == FLD_LAT) ? fin_vals.lat : lat_q;
		res_d.longitude = (!star_q && field_q == FLD_LON) ? fin_vals.lon : lon_q;
		res_d.fix_quality = (!star_q && field_q == FLD_FIX) ? fin_vals.fix : fix_q;
		res_d.altitude  = (!star_q && field_q == FLD_ALT) ? fin_vals.alt : alt_q;
		res_d.latitude_hemisphere =
			(!star_q && field_q == FLD_LAT_DIR && dir_first) ? byte_s1 : lat_dir_q;
		res_d.longitude_hemisphere =
			(!star_q && field_q == FLD_LON_DIR && dir_first) ? byte_s1 : lon_dir_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			byte_s1 <= chars.payload.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q       <= '0;
			capturing_q <= 1'b0;
			len_q       <= '0;
			field_q     <= '0;
			star_q      <= 1'b0;
			num_q       <= '0;
			lat_q       <= '0;
			lon_q       <= '0;
			lat_dir_q   <= CH_SPACE;
			lon_dir_q   <= CH_SPACE;
			fix_q       <= '0;
			alt_q       <= '0;
		end else if (step) begin
			if (!capturing_q) begin
				// hunt for the sentence prefix
				win_q <= win_next;
				if (win_next == PREFIX_GPGGA) begin
					capturing_q <= 1'b1;
					len_q       <= LEN_START;
					field_q     <= '0;
					star_q      <= 1'b0;
					num_q       <= '0;
					lat_q       <= '0;
					lon_q       <= '0;
					lat_dir_q   <= CH_SPACE;
					lon_dir_q   <= CH_SPACE;
					fix_q       <= '0;
					alt_q       <= '0;
				end
			end else if (over) begin
				// drop the overlong sentence
				capturing_q <= 1'b0;
				len_q       <= '0;
			end else if (is_lf) begin
				capturing_q <= 1'b0;
				len_q       <= '0;
			end else begin
				len_q <= len_q + LEN_ONE;
				if (!star_q) begin
					if (is_comma || is_end) begin
						// close the field: commit its value, clear the number
						lat_q <= res_d.latitude;
						lon_q <= res_d.longitude;
						fix_q <= res_d.fix_quality;
						alt_q <= res_d.altitude;
						num_q <= '0;
						if (is_end) begin
							star_q <= 1'b1;
						end else if (field_q != FLD_LAST) begin
							field_q <= field_q + 4'd1;
						end
					end else begin
						num_q     <= num_take;
						lat_dir_q <= res_d.latitude_hemisphere;
						lon_dir_q <= res_d.longitude_hemisphere;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= step && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			res_q <= res_d;
		end
	end

	assign fixes.valid   = res_valid_q;
	assign fixes.payload = res_q;
endmodule
